FILE: rtl/core/state_space_plant_step_unit_defines.svh
// assertion macros shared by the plant step unit files
`ifndef STATE_SPACE_PLANT_STEP_UNIT_DEFINES_SVH
`define STATE_SPACE_PLANT_STEP_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ssps_pkg.sv
// types, constants and saturation helpers for the plant step unit
package ssps_pkg;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STATE_W = 48;
  localparam int unsigned PROD_W  = COEF_W + STATE_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ADDR_W  = 5;

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_G_TOP0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_G_TOP1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_G_TOP2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_H_GAIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_C_OUT0 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_C_OUT1 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_C_OUT2 = 3'd6;

  localparam logic signed [COEF_W-1:0] RST_G_TOP0 = 32'sd730823350;
  localparam logic signed [COEF_W-1:0] RST_G_TOP1 = -32'sd680122681;
  localparam logic signed [COEF_W-1:0] RST_G_TOP2 = 32'sd216720932;
  localparam logic signed [COEF_W-1:0] RST_H_GAIN = 32'sd268435456;
  localparam logic signed [COEF_W-1:0] RST_C_OUT0 = 32'sd178634;
  localparam logic signed [COEF_W-1:0] RST_C_OUT1 = 32'sd674727;
  localparam logic signed [COEF_W-1:0] RST_C_OUT2 = 32'sd160495;

  typedef struct packed {
    logic signed [COEF_W-1:0] g_top0;
    logic signed [COEF_W-1:0] g_top1;
    logic signed [COEF_W-1:0] g_top2;
    logic signed [COEF_W-1:0] h_gain;
    logic signed [COEF_W-1:0] c_out0;
    logic signed [COEF_W-1:0] c_out1;
    logic signed [COEF_W-1:0] c_out2;
  } coef_bank_t;

  function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] top;
    top = v[SUM_W-1:DATA_W-1];
    if ((&top) || !(|top)) return v[DATA_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(DATA_W-1){1'b0}}};
    else return {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-STATE_W:0] top;
    top = v[SUM_W-1:STATE_W-1];
    if ((&top) || !(|top)) return v[STATE_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(STATE_W-1){1'b0}}};
    else return {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

endpackage

FILE: rtl/core/ssps_regs.sv
// coefficient register file behind the configuration port
module ssps_regs
  import ssps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output coef_bank_t        coef
);

  coef_bank_t           bank_r;
  coef_bank_t           bank_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign coef   = bank_r;

  always_comb begin
    bank_nxt = bank_r;
    if (wr_en) begin
      unique case (idx)
        REG_G_TOP0: bank_nxt.g_top0 = pwdata;
        REG_G_TOP1: bank_nxt.g_top1 = pwdata;
        REG_G_TOP2: bank_nxt.g_top2 = pwdata;
        REG_H_GAIN: bank_nxt.h_gain = pwdata;
        REG_C_OUT0: bank_nxt.c_out0 = pwdata;
        REG_C_OUT1: bank_nxt.c_out1 = pwdata;
        REG_C_OUT2: bank_nxt.c_out2 = pwdata;
        default:    bank_nxt = bank_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_G_TOP0: prdata = bank_r.g_top0;
      REG_G_TOP1: prdata = bank_r.g_top1;
      REG_G_TOP2: prdata = bank_r.g_top2;
      REG_H_GAIN: prdata = bank_r.h_gain;
      REG_C_OUT0: prdata = bank_r.c_out0;
      REG_C_OUT1: prdata = bank_r.c_out1;
      REG_C_OUT2: prdata = bank_r.c_out2;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r.g_top0 <= RST_G_TOP0;
      bank_r.g_top1 <= RST_G_TOP1;
      bank_r.g_top2 <= RST_G_TOP2;
      bank_r.h_gain <= RST_H_GAIN;
      bank_r.c_out0 <= RST_C_OUT0;
      bank_r.c_out1 <= RST_C_OUT1;
      bank_r.c_out2 <= RST_C_OUT2;
    end else begin
      bank_r <= bank_nxt;
    end
  end

endmodule

FILE: rtl/core/ssps_tprod.sv
// truncated coefficient-by-state product, split into two partial products
module ssps_tprod
  import ssps_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  logic signed [COEF_W-1:0]  coef,
  input  logic signed [STATE_W-1:0] data,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [COEF_W:0]          lo_op;
  logic signed [COEF_W+32:0]       lo_p;
  logic signed [STATE_W-32-1:0]    hi_op;
  logic signed [COEF_W+STATE_W-33:0] hi_p;
  logic signed [PROD_W-1:0]        full;

  // low 32 bits of the state are unsigned, the top 16 carry the sign
  assign lo_op = $signed({1'b0, data[31:0]});
  assign hi_op = data[STATE_W-1:32];
  assign lo_p  = coef * lo_op;
  assign hi_p  = coef * hi_op;
  assign full  = $signed({{(PROD_W-COEF_W-33){lo_p[COEF_W+32]}}, lo_p})
               + $signed({hi_p, 32'b0});
  assign prod  = full >>> COEF_FRAC_BITS;

endmodule

FILE: rtl/core/ssps_datapath.sv
// plant state registers, output dot product and state update
`include "state_space_plant_step_unit_defines.svh"

module ssps_datapath
  import ssps_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic signed [DATA_W-1:0] drive,
  input  coef_bank_t               coef,
  output logic signed [DATA_W-1:0] y_nxt
);

  logic signed [STATE_W-1:0] state_a_r, state_b_r, state_c_r;
  logic signed [STATE_W-1:0] state_a_nxt;
  logic signed [STATE_W-1:0] drive_ext;
  logic signed [PROD_W-1:0]  py0, py1, py2;
  logic signed [PROD_W-1:0]  px0, px1, px2, px3;
  logic signed [SUM_W-1:0]   y_sum, x_sum;

  assign drive_ext = {{(STATE_W-DATA_W){drive[DATA_W-1]}}, drive};

  ssps_tprod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_py0 (
    .coef(coef.c_out0), .data(state_a_r), .prod(py0));
  ssps_tprod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_py1 (
    .coef(coef.c_out1), .data(state_b_r), .prod(py1));
  ssps_tprod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_py2 (
    .coef(coef.c_out2), .data(state_c_r), .prod(py2));
  ssps_tprod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_px0 (
    .coef(coef.g_top0), .data(state_a_r), .prod(px0));
  ssps_tprod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_px1 (
    .coef(coef.g_top1), .data(state_b_r), .prod(px1));
  ssps_tprod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_px2 (
    .coef(coef.g_top2), .data(state_c_r), .prod(px2));
  ssps_tprod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_px3 (
    .coef(coef.h_gain), .data(drive_ext), .prod(px3));

  assign y_sum = $signed({{2{py0[PROD_W-1]}}, py0}) + $signed({{2{py1[PROD_W-1]}}, py1})
               + $signed({{2{py2[PROD_W-1]}}, py2});
  assign x_sum = $signed({{2{px0[PROD_W-1]}}, px0}) + $signed({{2{px1[PROD_W-1]}}, px1})
               + $signed({{2{px2[PROD_W-1]}}, px2}) + $signed({{2{px3[PROD_W-1]}}, px3});

  assign y_nxt       = sat_out(y_sum);
  assign state_a_nxt = sat_state(x_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_a_r <= '0;
      state_b_r <= '0;
      state_c_r <= '0;
    end else if (step) begin
      state_a_r <= state_a_nxt;
      state_b_r <= state_a_r;
      state_c_r <= state_b_r;
    end
  end

  // shift rows of the companion form move state down exactly
  `SSPS_ASSERT_NEXT(a_shift_b, clk, rst_n, step, state_b_r == $past(state_a_r), "state_b shift lost")
  `SSPS_ASSERT_NEXT(a_hold_c, clk, rst_n, !step, $stable(state_c_r), "state moved without a step")

endmodule

FILE: rtl/core/state_space_plant_step_unit.sv
// top level of the third-order state-space plant step unit
// Third-order discrete plant model. Each request on the in_ channel carries one
// input sample (Q16.16) and produces exactly one output sample on the out_
// channel: y = C.x from the state as it stood before the sample, saturated
// to 32 bits. The state then advances as x = G.x + H.u with a programmable
// top row of G and a fixed shift of state_a into state_b and state_b into
// state_c; state_a saturates at 48 bits.
// Both channels use valid/ready. A request is registered in the input stage
// on acceptance; its result is registered in the output register, raising
// out_valid, when the input stage advances into a free or draining output.
// Throughput is one sample per cycle while the receiver does not stall, set
// by the state feedback loop, which closes through four parallel truncated
// products and their sum, all combinational.
// If the receiver stalls, the result holds in the output register, one more
// request is taken into the input register and in_ready then drops until
// out_ready returns.
// Reset (rst_n, synchronous) clears the state and both valid flags and loads
// the coefficient defaults. The user must write coefficients through the APB
// port only while no request is in flight; the block does not enforce it.
`include "state_space_plant_step_unit_defines.svh"

module state_space_plant_step_unit
  import ssps_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_drive_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_plant_out,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  coef_bank_t               coef;
  logic                     s1_valid_r, s1_valid_nxt;
  logic signed [DATA_W-1:0] s1_drive_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_plant_r;
  logic signed [DATA_W-1:0] y_nxt;
  logic                     advance;
  logic                     in_take;

  ssps_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef   (coef)
  );

  ssps_datapath #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_datapath (
    .clk  (clk),
    .rst_n(rst_n),
    .step (advance),
    .drive(s1_drive_r),
    .coef (coef),
    .y_nxt(y_nxt)
  );

  // input stage moves on when the output register is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  assign out_valid     = out_valid_r;
  assign out_plant_out = out_plant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_drive_r <= in_drive_in;
    end
    if (advance) begin
      out_plant_r <= y_nxt;
    end
  end

  // a stalled, full pipeline must not take another request
  `SSPS_ASSERT_NOW(a_no_overrun, clk, rst_n, s1_valid_r && out_valid_r && !out_ready, !in_ready, "input stage overrun")
  `SSPS_ASSERT_NEXT(a_advance_out, clk, rst_n, advance, out_valid_r, "advanced request produced no result")

endmodule

FILE: tb/sv/tb_state_space_plant_step_unit.sv
// testbench for the third-order state-space plant step unit
`timescale 1ns / 100ps

module tb_state_space_plant_step_unit;
  import ssps_pkg::*;

  localparam int unsigned COEF_FRAC = 28;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum {COEF_WIDE, COEF_DAMPED, COEF_RESET, COEF_SCALED} coef_mix_t;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    int unsigned gap;
    bit drain;
  } sample_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] in_drive_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_plant_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // plant model: coefficient registers and Q32.16 state
  logic signed [COEF_W-1:0] coef_regs [7];
  logic signed [STATE_W-1:0] st_a, st_b, st_c;

  sample_req_t pending_samples [$];
  logic signed [DATA_W-1:0] plant_out_due [$];

  int issued_n = 0;
  int accepted_n = 0;
  int results_n = 0;
  int taken_seen = 0;
  int send_wait = 0;
  int recv_wait = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int mismatches = 0;
  int out_clips = 0;
  int state_clips = 0;
  int coef_loads = 0;

  state_space_plant_step_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_drive_in  (in_drive_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_plant_out(out_plant_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // exact product, then truncation toward minus infinity
  function automatic logic signed [95:0] scaled_product(input logic signed [31:0] coef,
                                                        input logic signed [47:0] x);
    logic signed [95:0] full;
    full = coef * x;
    return full >>> COEF_FRAC;
  endfunction

  function automatic logic signed [95:0] clamp_to(input logic signed [95:0] v,
                                                  input int unsigned w);
    logic signed [95:0] top_lim, bot_lim;
    top_lim = (96'sd1 <<< (w - 1)) - 96'sd1;
    bot_lim = -(96'sd1 <<< (w - 1));
    if (v > top_lim) return top_lim;
    if (v < bot_lim) return bot_lim;
    return v;
  endfunction

  // output from the old state, then the companion-form state update
  function automatic logic signed [DATA_W-1:0] advance_plant(input logic signed [DATA_W-1:0] u);
    logic signed [95:0] acc, lim;
    logic signed [DATA_W-1:0] y;
    acc = scaled_product(coef_regs[REG_C_OUT0], st_a)
        + scaled_product(coef_regs[REG_C_OUT1], st_b)
        + scaled_product(coef_regs[REG_C_OUT2], st_c);
    lim = clamp_to(acc, DATA_W);
    if (lim != acc) out_clips++;
    y = lim[DATA_W-1:0];
    acc = scaled_product(coef_regs[REG_G_TOP0], st_a)
        + scaled_product(coef_regs[REG_G_TOP1], st_b)
        + scaled_product(coef_regs[REG_G_TOP2], st_c)
        + scaled_product(coef_regs[REG_H_GAIN], u);
    lim = clamp_to(acc, STATE_W);
    if (lim != acc) state_clips++;
    st_c = st_b;
    st_b = st_a;
    st_a = lim[STATE_W-1:0];
    return y;
  endfunction

  task automatic report_miss(input string what, input bit has_want, input logic [31:0] want,
                             input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      if (has_want)
        $display("mismatch (%s): expected %0d, got %0d", what, $signed(want), $signed(got));
      else
        $display("mismatch (%s): got %0d with nothing pending", what, $signed(got));
    end
  endtask

  // sender: one request at a time, idle gap drawn per item
  always @(negedge clk) begin
    sample_req_t nxt;
    if (rst_n && issued_n == accepted_n) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0 &&
                   !(pending_samples[0].drain && plant_out_due.size() != 0)) begin
        nxt = pending_samples.pop_front();
        in_drive_in <= nxt.drive;
        in_valid <= 1'b1;
        send_wait = nxt.gap;
        issued_n++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall drawn after each taken result
  always @(negedge clk) begin
    if (rst_n) begin
      if (results_n != taken_seen) begin
        taken_seen = results_n;
        recv_wait = recv_idle ? $urandom_range(0, 15) : 0;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // check results before queueing the prediction for a request taken on the same edge
  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_n <= results_n + 1;
        if (plant_out_due.size() == 0) begin
          report_miss("plant_out", 1'b0, '0, out_plant_out);
        end else begin
          want = plant_out_due.pop_front();
          if (out_plant_out !== want) report_miss("plant_out", 1'b1, want, out_plant_out);
        end
      end
      if (in_valid && in_ready) begin
        plant_out_due.push_back(advance_plant(in_drive_in));
        accepted_n <= accepted_n + 1;
      end
    end
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx <= REG_C_OUT2) coef_regs[idx] = val;
  endtask

  task automatic apb_read_check(input logic [REG_IDX_W-1:0] idx);
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== coef_regs[idx]) report_miss("register readback", 1'b1, coef_regs[idx], got);
  endtask

  task automatic load_coefs(input coef_bank_t b);
    apb_write(REG_G_TOP0, b.g_top0);
    apb_write(REG_G_TOP1, b.g_top1);
    apb_write(REG_G_TOP2, b.g_top2);
    apb_write(REG_H_GAIN, b.h_gain);
    apb_write(REG_C_OUT0, b.c_out0);
    apb_write(REG_C_OUT1, b.c_out1);
    apb_write(REG_C_OUT2, b.c_out2);
    // address past the last register must leave everything alone
    apb_write(REG_SPARE, $urandom);
    for (int i = 0; i <= REG_C_OUT2; i++) apb_read_check(i[REG_IDX_W-1:0]);
    coef_loads++;
  endtask

  task automatic pick_coefs(input coef_mix_t mix, output coef_bank_t b);
    case (mix)
      COEF_WIDE: begin
        b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      COEF_DAMPED: begin
        // top row within +-0.25 keeps the state bounded
        b.g_top0 = $urandom_range(0, 1 << 27) - (1 << 26);
        b.g_top1 = $urandom_range(0, 1 << 27) - (1 << 26);
        b.g_top2 = $urandom_range(0, 1 << 27) - (1 << 26);
        b.h_gain = $signed($urandom) >>> $urandom_range(0, 31);
        b.c_out0 = $urandom;
        b.c_out1 = $urandom;
        b.c_out2 = $urandom;
      end
      COEF_RESET: begin
        b = {RST_G_TOP0, RST_G_TOP1, RST_G_TOP2, RST_H_GAIN, RST_C_OUT0, RST_C_OUT1, RST_C_OUT2};
      end
      default: begin
        b.g_top0 = $signed($urandom) >>> $urandom_range(0, 31);
        b.g_top1 = $signed($urandom) >>> $urandom_range(0, 31);
        b.g_top2 = $signed($urandom) >>> $urandom_range(0, 31);
        b.h_gain = $signed($urandom) >>> $urandom_range(0, 31);
        b.c_out0 = $signed($urandom) >>> $urandom_range(0, 31);
        b.c_out1 = $signed($urandom) >>> $urandom_range(0, 31);
        b.c_out2 = $signed($urandom) >>> $urandom_range(0, 31);
      end
    endcase
  endtask

  task automatic queue_sample(input logic signed [DATA_W-1:0] v, input bit drain);
    sample_req_t r;
    r.drive = v;
    r.gap = send_idle ? $urandom_range(0, 15) : 0;
    r.drain = drain;
    pending_samples.push_back(r);
  endtask

  task automatic wait_quiet();
    while (pending_samples.size() != 0 || issued_n != accepted_n || plant_out_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    coef_bank_t bank;
    logic signed [DATA_W-1:0] v;
    coef_regs[REG_G_TOP0] = RST_G_TOP0;
    coef_regs[REG_G_TOP1] = RST_G_TOP1;
    coef_regs[REG_G_TOP2] = RST_G_TOP2;
    coef_regs[REG_H_GAIN] = RST_H_GAIN;
    coef_regs[REG_C_OUT0] = RST_C_OUT0;
    coef_regs[REG_C_OUT1] = RST_C_OUT1;
    coef_regs[REG_C_OUT2] = RST_C_OUT2;
    st_a = '0;
    st_b = '0;
    st_c = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i <= REG_C_OUT2; i++) apb_read_check(i[REG_IDX_W-1:0]);

    // reset coefficients, field extremes and unit steps back to back
    queue_sample(32'sd0, 1'b0);
    queue_sample(32'sd1, 1'b0);
    queue_sample(-32'sd1, 1'b0);
    queue_sample(S32_MAX, 1'b0);
    queue_sample(S32_MIN, 1'b0);
    queue_sample(32'sh00010000, 1'b0);
    queue_sample(-32'sh00010000, 1'b0);
    repeat (3) queue_sample(32'sd0, 1'b0);
    wait_quiet();

    // extreme gains drive the state and the output into both clip limits
    bank = {S32_MAX, S32_MIN, 32'sd0, S32_MAX, S32_MAX, S32_MIN, 32'sd1};
    load_coefs(bank);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (5) queue_sample(S32_MAX, 1'b0);
    repeat (6) queue_sample(S32_MIN, 1'b0);
    repeat (2) queue_sample(32'sd0, 1'b0);
    wait_quiet();

    // all-zero gains flush the state
    load_coefs('0);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    repeat (20) queue_sample($urandom, 1'b0);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      pick_coefs(coef_mix_t'(p % 4), bank);
      load_coefs(bank);
      send_idle = p[0];
      recv_idle = p[1];
      for (int k = 0; k < 110; k++) begin
        if (k % 3 == 0) v = $urandom;
        else v = $signed($urandom) >>> $urandom_range(0, 31);
        // one request per phase waits until the pipeline has drained
        queue_sample(v, k == 55);
      end
      wait_quiet();
    end

    repeat (8) @(negedge clk);
    $display("run covered %0d samples and %0d checked outputs over %0d coefficient loads",
             accepted_n, results_n, coef_loads);
    $display("predicted %0d clipped outputs and %0d clipped state updates",
             out_clips, state_clips);
    if (mismatches == 0 && plant_out_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ssps_pkg.sv
rtl/core/ssps_regs.sv
rtl/core/ssps_tprod.sv
rtl/core/ssps_datapath.sv
rtl/core/state_space_plant_step_unit.sv
tb/sv/tb_state_space_plant_step_unit.sv
